@@ hdl/cdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cdfs_pkg
// Shared types and constants for the CDF table sampler.
// ----------------------------------------------------------------------------
package cdfs_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    localparam int unsigned ENTRY_W   = 10;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ENTRIES_W = 11;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned STEP_W    = 1;

    localparam logic [PADDR_W-1:0]   REG_ENTRIES   = 3'd0;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 11'd1024;
    localparam logic [DATA_W-1:0]    SUM_MAX       = 32'hFFFF_FFFF;
    localparam logic [STEP_W-1:0]    MOD_FIRST     = 1'b1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_SAMPLE  = 1'b1;
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                command;
        logic [ENTRY_W-1:0]  entry_index;
        logic [DATA_W-1:0]   weight;
        logic [DATA_W-1:0]   uniform;
    } t_req;

    typedef struct packed {
        logic                kind;
        logic [ENTRY_W-1:0]  chosen_entry;
        logic [DATA_W-1:0]   cumulative;
        logic                saturated;
    } t_rsp;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
    } t_alu_in;

    typedef struct packed {
        logic                carry;
        logic [DATA_W-1:0]   res;
    } t_alu_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_LOAD,
        S_SRCH_RD,
        S_SRCH_CMP
    } t_state;

endpackage

@@ hdl/cdfs_alu.sv @@
// ----------------------------------------------------------------------------
// cdfs_alu
// Shared 32-bit add / subtract unit; carry is the add carry or the borrow.
// ----------------------------------------------------------------------------
module cdfs_alu (
    input  cdfs_pkg::t_alu_in  i_in,
    output cdfs_pkg::t_alu_out o_out
);

    logic [cdfs_pkg::DATA_W:0] w_wide;

    always_comb begin
        case (i_in.op)
            cdfs_pkg::ALU_ADD: w_wide = {1'b0, i_in.a} + {1'b0, i_in.b};
            cdfs_pkg::ALU_SUB: w_wide = {1'b0, i_in.a} - {1'b0, i_in.b};
            default:           w_wide = '0;
        endcase
    end

    assign o_out.carry = w_wide[cdfs_pkg::DATA_W];
    assign o_out.res   = w_wide[cdfs_pkg::DATA_W-1:0];

endmodule

@@ hdl/cdf_table_sampler.sv @@
// ----------------------------------------------------------------------------
// cdf_table_sampler
// Discrete distribution sampler: cumulative table load and binary search.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+---------------------------------
//   request   | start / busy            | i_req  (command, entry, weight, u)
//   result    | o_done, one-cycle pulse | o_rsp  (kind, entry, cum, sat)
//   config    | APB, pready tied high   | entries_in_use at address 0
//
// A load writes the table in S_LOAD, after index reduction in S_MOD when
// TABLE_DEPTH is below 1024. A sample takes floor or ceil of log2 n search
// steps for n entries in use: each step is one table read and one compare
// in the shared ALU. busy is high while a request is in work; the result
// cannot be held off. Synchronous active-low reset; the table is not cleared.
// ----------------------------------------------------------------------------
module cdf_table_sampler #(
    parameter int unsigned TABLE_DEPTH = cdfs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cdfs_pkg::t_req                i_req,
    output logic                          o_done,
    output cdfs_pkg::t_rsp                o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cdfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [cdfs_pkg::DATA_W-1:0]   pwdata,
    output logic [cdfs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = (AW + 1 > cdfs_pkg::ENTRIES_W) ? AW + 1
                                                                : cdfs_pkg::ENTRIES_W;
    localparam bit NEED_MOD = (TABLE_DEPTH < (2 ** cdfs_pkg::ENTRY_W));
    localparam int unsigned MOD_SHIFT = 20;
    localparam int unsigned MOD_RECIP = ((2 ** MOD_SHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH;
    localparam int unsigned PW = cdfs_pkg::ENTRY_W + MOD_SHIFT;
    localparam int unsigned QW = 2 * cdfs_pkg::ENTRY_W;

    cdfs_pkg::t_state                  r_state, n_state;
    cdfs_pkg::t_req                    r_req, n_req;
    logic [cdfs_pkg::ENTRY_W-1:0]      r_rem, n_rem;
    logic [cdfs_pkg::ENTRY_W-1:0]      r_quo, n_quo;
    logic [cdfs_pkg::STEP_W-1:0]       r_step, n_step;
    logic [AW-1:0]                     r_lo, n_lo;
    logic [AW-1:0]                     r_hi, n_hi;
    logic [AW-1:0]                     r_mid, n_mid;
    logic [cdfs_pkg::DATA_W-1:0]       r_sum, n_sum;
    logic [cdfs_pkg::ENTRIES_W-1:0]    r_entries, n_entries;
    logic                              r_done, n_done;
    cdfs_pkg::t_rsp                    r_rsp, n_rsp;

    logic [cdfs_pkg::DATA_W-1:0]       r_mem [TABLE_DEPTH];
    logic [cdfs_pkg::DATA_W-1:0]       r_rdata;

    logic                              w_we;
    logic [AW-1:0]                     w_raddr;
    logic [cdfs_pkg::DATA_W-1:0]       w_sum;
    logic [cdfs_pkg::DATA_W-1:0]       w_base;
    logic [AW:0]                       w_mid_sum;
    logic [AW-1:0]                     w_mid;
    logic [CW-1:0]                     w_entries;
    logic [CW-1:0]                     w_n;
    logic [AW-1:0]                     w_last;
    logic [PW-1:0]                     w_prod;
    logic [QW-1:0]                     w_qd;
    logic                              w_cfg_wr;
    cdfs_pkg::t_alu_in                 w_alu_in;
    cdfs_pkg::t_alu_out                w_alu_out;

    cdfs_alu u_alu (
        .i_in  (w_alu_in),
        .o_out (w_alu_out)
    );

    // entries in use, clamped to 1..TABLE_DEPTH
    assign w_entries = CW'(r_entries);
    always_comb begin
        if (r_entries == '0) begin
            w_n = CW'(1);
        end else if (w_entries > CW'(TABLE_DEPTH)) begin
            w_n = CW'(TABLE_DEPTH);
        end else begin
            w_n = w_entries;
        end
    end
    assign w_last = AW'(w_n - CW'(1));

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[AW:1];
    assign w_raddr   = w_mid;
    assign w_base    = (r_req.entry_index == '0) ? '0 : r_sum;

    // index mod depth: reciprocal quotient, then index minus quotient * depth
    assign w_prod = PW'(r_rem) * PW'(MOD_RECIP);
    assign w_qd   = QW'(r_quo) * QW'(TABLE_DEPTH);

    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == cdfs_pkg::REG_ENTRIES) ? cdfs_pkg::DATA_W'(r_entries) : '0;

    assign busy   = (r_state != cdfs_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    always_comb begin
        case (r_state)
            cdfs_pkg::S_MOD: begin
                w_alu_in.op = cdfs_pkg::ALU_SUB;
                w_alu_in.a  = cdfs_pkg::DATA_W'(r_rem);
                w_alu_in.b  = cdfs_pkg::DATA_W'(w_qd);
            end
            cdfs_pkg::S_LOAD: begin
                w_alu_in.op = cdfs_pkg::ALU_ADD;
                w_alu_in.a  = w_base;
                w_alu_in.b  = r_req.weight;
            end
            default: begin
                w_alu_in.op = cdfs_pkg::ALU_SUB;
                w_alu_in.a  = r_req.uniform;
                w_alu_in.b  = r_rdata;
            end
        endcase
    end

    assign w_sum = w_alu_out.carry ? cdfs_pkg::SUM_MAX : w_alu_out.res;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_step    = r_step;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_sum     = r_sum;
        n_entries = r_entries;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        w_we      = 1'b0;

        if (w_cfg_wr && (paddr == cdfs_pkg::REG_ENTRIES)) begin
            n_entries = pwdata[cdfs_pkg::ENTRIES_W-1:0];
        end

        case (r_state)
            cdfs_pkg::S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_rem  = i_req.entry_index;
                    n_step = cdfs_pkg::MOD_FIRST;
                    n_lo   = '0;
                    n_hi   = w_last;
                    if (i_req.command == cdfs_pkg::CMD_SAMPLE) begin
                        n_state = cdfs_pkg::S_SRCH_RD;
                    end else if (NEED_MOD) begin
                        n_state = cdfs_pkg::S_MOD;
                    end else begin
                        n_state = cdfs_pkg::S_LOAD;
                    end
                end
            end
            cdfs_pkg::S_MOD: begin
                if (r_step != '0) begin
                    n_quo  = w_prod[PW-1:MOD_SHIFT];
                    n_step = r_step - 1'b1;
                end else begin
                    n_rem   = w_alu_out.res[cdfs_pkg::ENTRY_W-1:0];
                    n_state = cdfs_pkg::S_LOAD;
                end
            end
            cdfs_pkg::S_LOAD: begin
                w_we               = 1'b1;
                n_sum              = w_sum;
                n_rsp.kind         = cdfs_pkg::KIND_LOAD;
                n_rsp.chosen_entry = r_req.entry_index;
                n_rsp.cumulative   = w_sum;
                n_rsp.saturated    = (w_sum == cdfs_pkg::SUM_MAX);
                n_done             = 1'b1;
                n_state            = cdfs_pkg::S_IDLE;
            end
            cdfs_pkg::S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = cdfs_pkg::S_SRCH_CMP;
                end else begin
                    n_rsp.kind         = cdfs_pkg::KIND_SAMPLE;
                    n_rsp.chosen_entry = cdfs_pkg::ENTRY_W'(r_lo);
                    n_rsp.cumulative   = '0;
                    n_rsp.saturated    = 1'b0;
                    n_done             = 1'b1;
                    n_state            = cdfs_pkg::S_IDLE;
                end
            end
            cdfs_pkg::S_SRCH_CMP: begin
                // borrow of u - table[mid] means table[mid] > u
                if (w_alu_out.carry) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + AW'(1);
                end
                n_state = cdfs_pkg::S_SRCH_RD;
            end
            default: begin
                n_state = cdfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cdfs_pkg::S_IDLE;
            r_sum     <= '0;
            r_entries <= cdfs_pkg::ENTRIES_RESET;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_entries <= n_entries;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_rsp  <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[AW'(r_rem)] <= w_sum;
        end
        r_rdata <= r_mem[w_raddr];
    end

endmodule

@@ dv/cdf_table_sampler_tb.sv @@
// ----------------------------------------------------------------------------
// cdf_table_sampler_tb
// Self-checking bench for the CDF table sampler. Loads build cumulative
// tables and samples search them; a local predictor tracks the running sum,
// the table and the entries-in-use register. Every o_done result is checked
// field by field against the oldest prediction. Requests go out in random
// bursts. The register is written and read back between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cdf_table_sampler_tb;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start   = 1'b0;
    logic                           busy;
    cdfs_pkg::t_req                 i_req   = '0;
    logic                           o_done;
    cdfs_pkg::t_rsp                 o_rsp;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [cdfs_pkg::PADDR_W-1:0]   paddr   = '0;
    logic [cdfs_pkg::DATA_W-1:0]    pwdata  = '0;
    logic [cdfs_pkg::DATA_W-1:0]    prdata;
    logic                           pready;

    // predictor state
    logic [cdfs_pkg::DATA_W-1:0]    cdf_mem [1024];
    bit                             cdf_written [1024];
    logic [cdfs_pkg::DATA_W-1:0]    run_sum;
    logic [cdfs_pkg::ENTRIES_W-1:0] entries_cfg;

    cdfs_pkg::t_rsp                 awaited_q [$];
    cdfs_pkg::t_rsp                 oldest_rsp;
    int                             err_count = 0;
    int                             items_sent = 0;
    int                             burst_left = 0;

    cdf_table_sampler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 50) begin
            $display("ERROR %0t: %s", $time, what);
        end
    endtask

    function automatic int unsigned active_entries();
        int unsigned n;
        n = entries_cfg;
        if (n == 0) n = 1;
        if (n > 1024) n = 1024;
        return n;
    endfunction

    // binary search; flags a path through an entry never loaded
    function automatic logic [cdfs_pkg::ENTRY_W-1:0] search_cdf(
        input  logic [cdfs_pkg::DATA_W-1:0] u,
        output bit                          safe
    );
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo   = 0;
        hi   = active_entries() - 1;
        safe = 1'b1;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (!cdf_written[mid]) safe = 1'b0;
            if (cdf_mem[mid] > u) hi = mid;
            else lo = mid + 1;
        end
        return lo[cdfs_pkg::ENTRY_W-1:0];
    endfunction

    function automatic cdfs_pkg::t_rsp predict_cdf_step(input cdfs_pkg::t_req r);
        cdfs_pkg::t_rsp              res;
        logic [cdfs_pkg::DATA_W:0]   wide;
        logic [cdfs_pkg::DATA_W-1:0] base;
        bit                          safe;
        res = '0;
        if (r.command == cdfs_pkg::CMD_LOAD) begin
            base    = (r.entry_index == '0) ? '0 : run_sum;
            wide    = {1'b0, base} + {1'b0, r.weight};
            run_sum = wide[cdfs_pkg::DATA_W] ? cdfs_pkg::SUM_MAX
                                             : wide[cdfs_pkg::DATA_W-1:0];
            cdf_mem[r.entry_index]     = run_sum;
            cdf_written[r.entry_index] = 1'b1;
            res.kind         = cdfs_pkg::KIND_LOAD;
            res.chosen_entry = r.entry_index;
            res.cumulative   = run_sum;
            res.saturated    = (run_sum == cdfs_pkg::SUM_MAX);
        end else begin
            res.kind         = cdfs_pkg::KIND_SAMPLE;
            res.chosen_entry = search_cdf(r.uniform, safe);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (awaited_q.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                oldest_rsp = awaited_q.pop_front();
                if (o_rsp.kind !== oldest_rsp.kind)
                    report_mismatch($sformatf("kind %0b, want %0b",
                                              o_rsp.kind, oldest_rsp.kind));
                if (o_rsp.chosen_entry !== oldest_rsp.chosen_entry)
                    report_mismatch($sformatf("entry %0d, want %0d",
                                              o_rsp.chosen_entry, oldest_rsp.chosen_entry));
                if (o_rsp.cumulative !== oldest_rsp.cumulative)
                    report_mismatch($sformatf("cumulative %h, want %h",
                                              o_rsp.cumulative, oldest_rsp.cumulative));
                if (o_rsp.saturated !== oldest_rsp.saturated)
                    report_mismatch($sformatf("saturated %0b, want %0b",
                                              o_rsp.saturated, oldest_rsp.saturated));
            end
        end
    end

    // start stays high across a burst; a gap lowers it
    task automatic send_req(input cdfs_pkg::t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        awaited_q.push_back(predict_cdf_step(r));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    task automatic send_load(input logic [cdfs_pkg::ENTRY_W-1:0] idx,
                             input logic [cdfs_pkg::DATA_W-1:0]  w);
        cdfs_pkg::t_req r;
        r.command     = cdfs_pkg::CMD_LOAD;
        r.entry_index = idx;
        r.weight      = w;
        r.uniform     = $urandom;
        send_req(r);
    endtask

    // a sample whose search would touch an unloaded entry becomes a load
    task automatic send_sample(input logic [cdfs_pkg::DATA_W-1:0] u);
        cdfs_pkg::t_req r;
        bit             safe;
        void'(search_cdf(u, safe));
        r.command     = safe ? cdfs_pkg::CMD_SAMPLE : cdfs_pkg::CMD_LOAD;
        r.entry_index = cdfs_pkg::ENTRY_W'($urandom);
        r.weight      = $urandom;
        r.uniform     = u;
        send_req(r);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (awaited_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // read back the current value, then write the new one
    task automatic write_entries_cfg(input logic [cdfs_pkg::ENTRIES_W-1:0] v);
        logic [cdfs_pkg::DATA_W-1:0] rd;
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= cdfs_pkg::REG_ENTRIES;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        if (rd !== {{(cdfs_pkg::DATA_W-cdfs_pkg::ENTRIES_W){1'b0}}, entries_cfg})
            report_mismatch($sformatf("entries_in_use read %h, want %h", rd, entries_cfg));
        pwrite  <= 1'b1;
        penable <= 1'b0;
        pwdata  <= {{(cdfs_pkg::DATA_W-cdfs_pkg::ENTRIES_W){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        entries_cfg = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic draw_samples(input int m, input int span);
        int j;
        repeat (m) begin
            j = $urandom_range(0, span - 1);
            case ($urandom_range(0, 4))
                0:       send_sample(cdf_mem[j]);
                1:       send_sample(cdf_mem[j] - 1);
                default: send_sample($urandom);
            endcase
        end
    endtask

    // load entries 0..k-1 with weights summing near one, then sample
    task automatic run_distribution(input int k, input logic [cdfs_pkg::ENTRIES_W-1:0] n,
                                    input int m);
        longint unsigned             hi;
        logic [cdfs_pkg::DATA_W-1:0] w;
        hi = 2 * (64'hFFFF_FFFF / k);
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 15))
                0:       w = '0;
                1:       w = cdfs_pkg::SUM_MAX;
                default: w = $urandom_range(0, 32'(hi));
            endcase
            send_load(cdfs_pkg::ENTRY_W'(i), w);
        end
        write_entries_cfg(n);
        draw_samples(m, k);
    endtask

    task automatic test_entries_floor();
        write_entries_cfg('0);
        send_sample($urandom);
        write_entries_cfg(11'd1);
        send_sample(cdfs_pkg::SUM_MAX);
    endtask

    task automatic test_cumulative_sums();
        write_entries_cfg(11'd4);
        send_load(10'd0, 32'h4000_0000);
        send_load(10'd1, 32'h4000_0000);
        send_load(10'd2, 32'h4000_0000);
        send_load(10'd3, 32'h3FFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h3FFF_FFFF);
        send_sample(32'h4000_0000);
        send_sample(32'hBFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_saturation();
        send_load(10'd0, 32'hF000_0000);
        send_load(10'd1, 32'h2000_0000);
        send_load(10'd2, 32'h0000_0000);
        send_load(10'd3, 32'hFFFF_FFFF);
        send_load(10'd0, 32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFE);
    endtask

    task automatic test_out_of_order();
        send_load(10'd0, 32'h8000_0000);
        send_load(10'd2, 32'h0000_1000);
        send_load(10'd1, 32'h0000_0010);
        send_load(10'd1023, 32'h0000_0007);
        send_load(10'd0, 32'h0000_0000);
        send_sample(32'h8000_1008);
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
    endtask

    task automatic test_full_table();
        run_distribution(1024, 11'd1024, 20);
        write_entries_cfg(11'd2047);
        draw_samples(20, 1024);
        write_entries_cfg(11'd1025);
        draw_samples(10, 1024);
    endtask

    task automatic test_random_traffic();
        int target;
        int k;
        int sel;
        int remaining;
        target = 1800;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                sel = $urandom_range(0, 19);
                if (sel < 14) k = $urandom_range(1, 16);
                else if (sel < 19) k = $urandom_range(17, 128);
                else k = $urandom_range(129, 1024);
                remaining = target - items_sent;
                if (k > remaining) k = remaining;
                run_distribution(k,
                                 cdfs_pkg::ENTRIES_W'(($urandom_range(0, 3) == 0) ?
                                                      $urandom_range(0, k) : k),
                                 $urandom_range(4, 30));
            end else begin
                if ($urandom_range(0, 1))
                    write_entries_cfg(cdfs_pkg::ENTRIES_W'($urandom_range(0, 2047)));
                repeat ($urandom_range(3, 15)) begin
                    if ($urandom_range(0, 1))
                        send_load(($urandom_range(0, 3) == 0) ? '0
                                                              : cdfs_pkg::ENTRY_W'($urandom),
                                  $urandom);
                    else
                        send_sample($urandom);
                end
            end
        end
    endtask

    initial begin
        run_sum     = '0;
        entries_cfg = cdfs_pkg::ENTRIES_RESET;
        foreach (cdf_mem[i]) begin
            cdf_mem[i]     = '0;
            cdf_written[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_entries_floor();
        test_cumulative_sums();
        test_saturation();
        test_out_of_order();
        test_full_table();
        test_random_traffic();

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
